// ----- src/sng_pkg.sv -----
// Shared types and constants for the stereo noise gate.
// Holds formats, reset values, register indexes, sequencer states and commands.
// No dependencies.
`default_nettype none

package sng_pkg;

  // Sample and gain formats
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 16;
  localparam int GAIN_BITS   = 24;
  localparam int GAIN_FRAC   = 23;
  localparam int THR_BITS    = 20;
  localparam int HOLD_BITS   = 16;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 20;

  // Shared multiplier: signed operands wide enough for any sample or gain
  localparam int MUL_A_BITS = ((SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS) + 1;
  localparam int MUL_B_BITS = GAIN_BITS + 1;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  localparam logic [GAIN_BITS-1:0] UNITY    = GAIN_BITS'(1) << GAIN_FRAC;
  localparam logic [GAIN_BITS-1:0] SNAP_LSB = GAIN_BITS'(84);
  // Close threshold factor, about -6 dB in Q0.23
  localparam logic [GAIN_FRAC-1:0] HYST_Q23 = GAIN_FRAC'(4204263);

  // Register reset values
  localparam logic                 RST_ENABLE    = 1'b1;
  localparam logic [THR_BITS-1:0]  RST_THRESHOLD = THR_BITS'(26527);
  localparam logic [HOLD_BITS-1:0] RST_HOLD      = HOLD_BITS'(2400);
  localparam logic [COEF_BITS-1:0] RST_DET_ATT   = COEF_BITS'(60985);
  localparam logic [COEF_BITS-1:0] RST_DET_REL   = COEF_BITS'(65222);
  localparam logic [COEF_BITS-1:0] RST_GATE_ATT  = COEF_BITS'(64367);
  localparam logic [COEF_BITS-1:0] RST_GATE_REL  = COEF_BITS'(65489);
  localparam logic [COEF_BITS-1:0] RST_BYPASS    = COEF_BITS'(65326);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GATE_ENABLE  = 3'd0,
    REG_OPEN_THR     = 3'd1,
    REG_HOLD_LENGTH  = 3'd2,
    REG_DET_ATTACK   = 3'd3,
    REG_DET_RELEASE  = 3'd4,
    REG_GATE_ATTACK  = 3'd5,
    REG_GATE_RELEASE = 3'd6,
    REG_BYPASS_COEF  = 3'd7
  } sng_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV_MUL,
    ST_ENV_UPD,
    ST_GATE,
    ST_GAIN_MUL,
    ST_GAIN_UPD,
    ST_MIX_UPD,
    ST_APP_MUL,
    ST_APP_UPD,
    ST_LEFT_MUL,
    ST_RIGHT_MUL,
    ST_RIGHT_RND,
    ST_FINISH
  } sng_state_e;

  // Datapath commands, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_ENV_MUL,
    OP_ENV_UPD,
    OP_GATE,
    OP_GAIN_MUL,
    OP_GAIN_UPD,
    OP_MIX_UPD,
    OP_APP_MUL,
    OP_APP_UPD,
    OP_LEFT_MUL,
    OP_RIGHT_MUL,
    OP_RIGHT_RND,
    OP_LOAD_OUT
  } sng_op_e;

  typedef struct packed {
    logic out_free;
  } sng_status_t;

endpackage

`default_nettype wire

// ----- src/sng_ctrl.sv -----
// Sequencer for the noise gate: walks one item through the shared multiplier.
// Depends on sng_pkg for states, commands and status.
`default_nettype none

module sng_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sng_pkg::sng_status_t status_i,
  output sng_pkg::sng_op_e    op_o
);
  import sng_pkg::*;

  sng_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_ENV_MUL;
      ST_ENV_MUL:   state_d = ST_ENV_UPD;
      ST_ENV_UPD:   state_d = ST_GATE;
      ST_GATE:      state_d = ST_GAIN_MUL;
      ST_GAIN_MUL:  state_d = ST_GAIN_UPD;
      ST_GAIN_UPD:  state_d = ST_MIX_UPD;
      ST_MIX_UPD:   state_d = ST_APP_MUL;
      ST_APP_MUL:   state_d = ST_APP_UPD;
      ST_APP_UPD:   state_d = ST_LEFT_MUL;
      ST_LEFT_MUL:  state_d = ST_RIGHT_MUL;
      ST_RIGHT_MUL: state_d = ST_RIGHT_RND;
      ST_RIGHT_RND: state_d = ST_FINISH;
      ST_FINISH:    if (status_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    op_o       = OP_NONE;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) op_o = OP_CAPTURE;
      ST_ENV_MUL:   op_o = OP_ENV_MUL;
      ST_ENV_UPD:   op_o = OP_ENV_UPD;
      ST_GATE:      op_o = OP_GATE;
      ST_GAIN_MUL:  op_o = OP_GAIN_MUL;
      ST_GAIN_UPD:  op_o = OP_GAIN_UPD;
      ST_MIX_UPD:   op_o = OP_MIX_UPD;
      ST_APP_MUL:   op_o = OP_APP_MUL;
      ST_APP_UPD:   op_o = OP_APP_UPD;
      ST_LEFT_MUL:  op_o = OP_LEFT_MUL;
      ST_RIGHT_MUL: op_o = OP_RIGHT_MUL;
      ST_RIGHT_RND: op_o = OP_RIGHT_RND;
      ST_FINISH:    if (status_i.out_free) op_o = OP_LOAD_OUT;
      default:      op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/sng_dp.sv -----
// Datapath for the noise gate: config registers, gate state, shared multiplier
// and output register. Driven one command per cycle by sng_ctrl; uses sng_pkg.
`default_nettype none

module sng_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sng_pkg::sng_op_e                     op_i,
  output sng_pkg::sng_status_t                 status_o,
  input  logic                                 cfg_valid_i,
  input  logic [sng_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [sng_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  logic signed [sng_pkg::SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [sng_pkg::SAMPLE_BITS-1:0] right_sample_i,
  input  logic                                 stereo_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic signed [sng_pkg::SAMPLE_BITS-1:0] left_out_o,
  output logic signed [sng_pkg::SAMPLE_BITS-1:0] right_out_o,
  output logic [sng_pkg::GAIN_BITS-1:0]        applied_gain_o,
  output logic                                 muting_o,
  output logic                                 gate_is_open_o
);
  import sng_pkg::*;

  localparam int RND_W = PROD_BITS - GAIN_FRAC;
  localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (GAIN_FRAC - 1);
  localparam logic signed [RND_W-1:0] MAXV =
    {{(RND_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [RND_W-1:0] MINV =
    {{(RND_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  // Round half up and saturate a Q1.23-scaled product back to a sample
  function automatic logic signed [SAMPLE_BITS-1:0] sat_round(
    input logic signed [PROD_BITS-1:0] p
  );
    logic signed [PROD_BITS-1:0] sum;
    logic signed [RND_W-1:0]     r;
    sum = p + ROUND_HALF;
    r   = sum[PROD_BITS-1:GAIN_FRAC];
    if (r > MAXV) begin
      r = MAXV;
    end else if (r < MINV) begin
      r = MINV;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  // Configuration registers
  logic                 enable_q;
  logic [THR_BITS-1:0]  thr_q;
  logic [HOLD_BITS-1:0] hold_len_q;
  logic [COEF_BITS-1:0] det_att_q, det_rel_q, gate_att_q, gate_rel_q, bypass_q;

  // Gate state
  logic [SAMPLE_BITS-1:0] env_q;
  logic [GAIN_BITS-1:0]   gain_q, mix_q;
  logic [HOLD_BITS-1:0]   hold_q;
  logic                   open_q;

  // Per-item working registers
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;
  logic                          stereo_q;
  logic [SAMPLE_BITS-1:0]        level_q;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic [GAIN_BITS-1:0]          applied_q;
  logic signed [SAMPLE_BITS-1:0] left_res_q, right_res_q;
  logic                          out_valid_q;

  // Combinational helpers
  logic [SAMPLE_BITS-1:0] left_abs, right_abs, level_in;
  logic                   env_up;
  logic [SAMPLE_BITS-1:0] env_diff, env_step, env_new;
  logic [COEF_BITS-1:0]   env_coef, gain_coef;
  logic [GAIN_BITS-1:0]   gain_diff, gain_step, gain_raw, gain_new;
  logic [GAIN_BITS-1:0]   mix_diff, mix_step, mix_raw, mix_new;
  logic [PROD_BITS-1:0]   rnd_sum;
  logic [THR_BITS:0]      close_thr;
  logic [GAIN_BITS-1:0]   app_new;
  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [MUL_B_BITS-1:0] mul_b;

  // Detector level: peak of the absolute values of the channels in use
  assign left_abs  = left_sample_i[SAMPLE_BITS-1] ? $unsigned(-left_sample_i)
                                                 : $unsigned(left_sample_i);
  assign right_abs = right_sample_i[SAMPLE_BITS-1] ? $unsigned(-right_sample_i)
                                                  : $unsigned(right_sample_i);
  assign level_in  = (stereo_i && (right_abs > left_abs)) ? right_abs : left_abs;

  // Envelope one-pole step
  assign env_up   = level_q > env_q;
  assign env_diff = env_up ? (level_q - env_q) : (env_q - level_q);
  assign env_coef = env_up ? det_att_q : det_rel_q;
  assign env_step = prod_q[COEF_BITS +: SAMPLE_BITS];
  assign env_new  = env_up ? (level_q - env_step) : (level_q + env_step);

  // Gate gain step toward unity or zero, with snapping
  assign gain_diff = open_q ? (UNITY - gain_q) : gain_q;
  assign gain_coef = open_q ? gate_att_q : gate_rel_q;
  assign gain_step = prod_q[COEF_BITS +: GAIN_BITS];
  assign gain_raw  = open_q ? (UNITY - gain_step) : gain_step;
  assign gain_new  = open_q ? ((gain_raw > (UNITY - SNAP_LSB)) ? UNITY : gain_raw)
                            : ((gain_raw < SNAP_LSB) ? '0 : gain_raw);

  // Enable crossfade step
  assign mix_diff = enable_q ? (UNITY - mix_q) : mix_q;
  assign mix_step = prod_q[COEF_BITS +: GAIN_BITS];
  assign mix_raw  = enable_q ? (UNITY - mix_step) : mix_step;
  assign mix_new  = enable_q ? ((mix_raw > (UNITY - SNAP_LSB)) ? UNITY : mix_raw)
                             : ((mix_raw < SNAP_LSB) ? '0 : mix_raw);

  // Round the unsigned Q.23 product: close threshold and applied gain
  assign rnd_sum   = $unsigned(prod_q) + $unsigned(ROUND_HALF);
  assign close_thr = rnd_sum[GAIN_FRAC +: (THR_BITS + 1)];
  assign app_new   = UNITY - rnd_sum[GAIN_FRAC +: GAIN_BITS];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_i)
      OP_ENV_MUL: begin
        mul_a = $signed(MUL_A_BITS'(env_diff));
        mul_b = $signed(MUL_B_BITS'(env_coef));
      end
      OP_ENV_UPD: begin
        mul_a = $signed(MUL_A_BITS'(thr_q));
        mul_b = $signed(MUL_B_BITS'(HYST_Q23));
      end
      OP_GAIN_MUL: begin
        mul_a = $signed(MUL_A_BITS'(gain_diff));
        mul_b = $signed(MUL_B_BITS'(gain_coef));
      end
      OP_GAIN_UPD: begin
        mul_a = $signed(MUL_A_BITS'(mix_diff));
        mul_b = $signed(MUL_B_BITS'(bypass_q));
      end
      OP_APP_MUL: begin
        mul_a = $signed(MUL_A_BITS'(mix_q));
        mul_b = $signed(MUL_B_BITS'(UNITY - gain_q));
      end
      OP_LEFT_MUL: begin
        mul_a = MUL_A_BITS'(left_q);
        mul_b = $signed(MUL_B_BITS'(applied_q));
      end
      OP_RIGHT_MUL: begin
        mul_a = MUL_A_BITS'(right_q);
        mul_b = $signed(MUL_B_BITS'(applied_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= RST_ENABLE;
      thr_q      <= RST_THRESHOLD;
      hold_len_q <= RST_HOLD;
      det_att_q  <= RST_DET_ATT;
      det_rel_q  <= RST_DET_REL;
      gate_att_q <= RST_GATE_ATT;
      gate_rel_q <= RST_GATE_REL;
      bypass_q   <= RST_BYPASS;
    end else if (cfg_valid_i) begin
      unique case (sng_reg_e'(cfg_index_i))
        REG_GATE_ENABLE:  enable_q   <= cfg_data_i[0];
        REG_OPEN_THR:     thr_q      <= cfg_data_i[THR_BITS-1:0];
        REG_HOLD_LENGTH:  hold_len_q <= cfg_data_i[HOLD_BITS-1:0];
        REG_DET_ATTACK:   det_att_q  <= cfg_data_i[COEF_BITS-1:0];
        REG_DET_RELEASE:  det_rel_q  <= cfg_data_i[COEF_BITS-1:0];
        REG_GATE_ATTACK:  gate_att_q <= cfg_data_i[COEF_BITS-1:0];
        REG_GATE_RELEASE: gate_rel_q <= cfg_data_i[COEF_BITS-1:0];
        REG_BYPASS_COEF:  bypass_q   <= cfg_data_i[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Gate state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q  <= '0;
      gain_q <= '0;
      mix_q  <= RST_ENABLE ? UNITY : '0;
      hold_q <= '0;
      open_q <= 1'b0;
    end else begin
      unique case (op_i)
        OP_ENV_UPD: env_q <= env_new;
        OP_GATE: begin
          if (!open_q) begin
            if (env_q >= SAMPLE_BITS'(thr_q)) begin
              open_q <= 1'b1;
              hold_q <= hold_len_q;
            end
          end else if (env_q >= SAMPLE_BITS'(close_thr)) begin
            hold_q <= hold_len_q;
          end else if (hold_q != '0) begin
            hold_q <= hold_q - 1'b1;
          end else begin
            open_q <= 1'b0;
          end
        end
        OP_GAIN_UPD: gain_q <= gain_new;
        OP_MIX_UPD:  mix_q  <= mix_new;
        default: ;
      endcase
    end
  end

  // Working registers, multiplier product and result payload
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (op_i)
      OP_CAPTURE: begin
        left_q   <= left_sample_i;
        right_q  <= right_sample_i;
        stereo_q <= stereo_i;
        level_q  <= level_in;
      end
      OP_APP_UPD:   applied_q   <= app_new;
      OP_RIGHT_MUL: left_res_q  <= sat_round(prod_q);
      OP_RIGHT_RND: right_res_q <= stereo_q ? sat_round(prod_q) : '0;
      OP_LOAD_OUT: begin
        left_out_o     <= left_res_q;
        right_out_o    <= right_res_q;
        applied_gain_o <= applied_q;
        muting_o       <= enable_q && (applied_q < (UNITY >> 1));
        gate_is_open_o <= open_q;
      end
      default: ;
    endcase
  end

  // Output register valid: set on load, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OP_LOAD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// ----- src/stereo_noise_gate_top.sv -----
// Stereo noise gate with hysteresis and hold, top level.
// The sequencer steps one shared 25x25 multiplier through each accepted item and takes
// no new item until that result is loaded; loading waits while a stalled result is held.
// A waiting result sits in the output register while the next item is taken.
// Reset (rst_ni low, asynchronous) restores register defaults, closes the gate,
// zeroes envelope and gain, and sets the enable crossfade to unity.
`default_nettype none

module stereo_noise_gate_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [sng_pkg::SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [sng_pkg::SAMPLE_BITS-1:0] right_sample_i,
  input  logic                                   stereo_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [sng_pkg::SAMPLE_BITS-1:0] left_out_o,
  output logic signed [sng_pkg::SAMPLE_BITS-1:0] right_out_o,
  output logic [sng_pkg::GAIN_BITS-1:0]          applied_gain_o,
  output logic                                   muting_o,
  output logic                                   gate_is_open_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [sng_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [sng_pkg::CFG_DATA_BITS-1:0]      cfg_data_i
);
  import sng_pkg::*;

  sng_op_e     op;
  sng_status_t status;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  sng_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .op_o       (op)
  );

  sng_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .stereo_i       (stereo_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .applied_gain_o (applied_gain_o),
    .muting_o       (muting_o),
    .gate_is_open_o (gate_is_open_o)
  );

endmodule

`default_nettype wire

// ----- src/sng_checker.sv -----
// Port-level checks for the noise gate, bound to stereo_noise_gate_top.
// Depends on sng_pkg for widths and the unity gain constant.
`default_nettype none

module sng_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [sng_pkg::SAMPLE_BITS-1:0] right_out_o,
  input logic [sng_pkg::GAIN_BITS-1:0]          applied_gain_o,
  input logic                                   muting_o
);
  import sng_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One item at a time: an accepted item blocks the input next cycle
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // Applied gain never exceeds unity
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> applied_gain_o <= UNITY)
    else $error("applied gain above unity");

  // Muting flag agrees with the applied gain
  a_muting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && muting_o |-> applied_gain_o < (UNITY >> 1))
    else $error("muting set with gain at or above one half");

  // Zero gain silences the right channel
  a_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (applied_gain_o == '0) |-> right_out_o == '0)
    else $error("nonzero output at zero gain");

endmodule

bind stereo_noise_gate_top sng_checker u_sng_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .right_out_o    (right_out_o),
  .applied_gain_o (applied_gain_o),
  .muting_o       (muting_o)
);

`default_nettype wire
